### hw/rtl/dtt_pkg.sv
// Shared types and constants for the dirty tile tracker.
// Used by dtt_front, dtt_back and dirty_tile_tracker; depends on nothing else.
package dtt_pkg;

	localparam int TILE_LOG2 = 5;
	localparam int TILE_SIZE = 1 << TILE_LOG2;
	localparam int DEF_MAX_TILES_X = 128;
	localparam int DEF_MAX_TILES_Y = 128;
	localparam int PIX_W = 13;
	localparam int RECTS_W = 7;
	localparam logic [RECTS_W-1:0] CAP_LIMIT = 7'd64;

	localparam logic [PIX_W-1:0] RST_SCREEN_WIDTH = 13'd1024;
	localparam logic [PIX_W-1:0] RST_SCREEN_HEIGHT = 13'd768;
	localparam logic [RECTS_W-1:0] RST_MAX_RECTS = 7'd1;

	localparam logic [1:0] REG_SCREEN_WIDTH = 2'd0;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MAX_RECTS = 2'd2;

	typedef enum logic [1:0] {
		CMD_MARK  = 2'd0,
		CMD_ALL   = 2'd1,
		CMD_FLUSH = 2'd2
	} cmd_t;

endpackage

### hw/rtl/dtt_front.sv
// Front end of the dirty tile tracker: accepts command words, converts mark
// regions to tile bounds, drops no-op commands and queues the rest.
// Depends on dtt_pkg.
module dtt_front import dtt_pkg::*; #(
	parameter int MAX_TILES_X = DEF_MAX_TILES_X,
	parameter int MAX_TILES_Y = DEF_MAX_TILES_Y,
	localparam int TXW = $clog2(MAX_TILES_X + 1),
	localparam int TYW = $clog2(MAX_TILES_Y + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [55:0]    s_tdata,
	input  logic [1:0]     s_tuser,
	input  logic [TXW-1:0] ntx,
	input  logic [TYW-1:0] nty,
	output logic           q_valid,
	input  logic           q_ready,
	output cmd_t           q_kind,
	output logic [TXW-1:0] q_sx,
	output logic [TXW-1:0] q_ex,
	output logic [TYW-1:0] q_sy,
	output logic [TYW-1:0] q_ey
);

	logic [11:0] x, y;
	logic [12:0] rw, rh;
	logic [13:0] xe, ye, xt, yt, sx_w, sy_w, ex_w, ey_w;
	logic        keep, push, pop;

	cmd_t           kind_q [2];
	logic [TXW-1:0] sx_q [2];
	logic [TXW-1:0] ex_q [2];
	logic [TYW-1:0] sy_q [2];
	logic [TYW-1:0] ey_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;

	always_comb begin
		x = s_tdata[11:0];
		y = s_tdata[23:12];
		rw = s_tdata[36:24];
		rh = s_tdata[49:37];
		xe = 14'(x) + 14'(rw);
		ye = 14'(y) + 14'(rh);
		xt = (xe + 14'(TILE_SIZE - 1)) >> TILE_LOG2;
		yt = (ye + 14'(TILE_SIZE - 1)) >> TILE_LOG2;
		ex_w = (xt > 14'(ntx)) ? 14'(ntx) : xt;
		ey_w = (yt > 14'(nty)) ? 14'(nty) : yt;
		sx_w = 14'(x >> TILE_LOG2);
		sy_w = 14'(y >> TILE_LOG2);
		keep = 1'b0;
		case (s_tuser)
			CMD_MARK:  keep = (sx_w < ex_w) && (sy_w < ey_w);
			CMD_ALL:   keep = 1'b1;
			CMD_FLUSH: keep = 1'b1;
			default:   keep = 1'b0;
		endcase
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push = s_tvalid && s_tready && keep;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;

	assign q_kind = kind_q[rp_q];
	assign q_sx = sx_q[rp_q];
	assign q_ex = ex_q[rp_q];
	assign q_sy = sy_q[rp_q];
	assign q_ey = ey_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wp_q] <= cmd_t'(s_tuser);
			sx_q[wp_q] <= sx_w[TXW-1:0];
			ex_q[wp_q] <= ex_w[TXW-1:0];
			sy_q[wp_q] <= sy_w[TYW-1:0];
			ey_q[wp_q] <= ey_w[TYW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### hw/rtl/dtt_back.sv
// Back end of the dirty tile tracker: holds the tile map memory, applies marks
// one row per cycle, on a flush scans rows or sends the whole screen, and
// drives the result register. Depends on dtt_pkg.
module dtt_back import dtt_pkg::*; #(
	parameter int MAX_TILES_X = DEF_MAX_TILES_X,
	parameter int MAX_TILES_Y = DEF_MAX_TILES_Y,
	localparam int TXW = $clog2(MAX_TILES_X + 1),
	localparam int TYW = $clog2(MAX_TILES_Y + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  cmd_t               q_kind,
	input  logic [TXW-1:0]     q_sx,
	input  logic [TXW-1:0]     q_ex,
	input  logic [TYW-1:0]     q_sy,
	input  logic [TYW-1:0]     q_ey,
	input  logic [TXW-1:0]     ntx,
	input  logic [TYW-1:0]     nty,
	input  logic [PIX_W-1:0]   screen_width,
	input  logic [PIX_W-1:0]   screen_height,
	input  logic [RECTS_W-1:0] max_rects,
	input  logic               cfg_mark_all,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [55:0]        m_tdata,
	output logic [1:0]         m_tuser,
	output logic               m_tlast
);

	localparam int W = MAX_TILES_X;
	localparam int RAW = (MAX_TILES_Y > 1) ? $clog2(MAX_TILES_Y) : 1;
	localparam int XPW = TXW + TILE_LOG2;
	localparam int YPW = TYW + TILE_LOG2;
	localparam int XCW = (XPW > PIX_W) ? XPW : PIX_W;
	localparam int YCW = (YPW > PIX_W) ? YPW : PIX_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MARK, ST_MDRAIN, ST_WHOLE, ST_RD, ST_WAIT, ST_RUNS, ST_END, ST_CLEAR
	} state_t;

	typedef struct packed {
		logic [PIX_W-1:0] x1;
		logic [PIX_W-1:0] y1;
		logic [PIX_W-1:0] x2;
		logic [PIX_W-1:0] y2;
	} rect_t;

	function automatic logic [TXW-1:0] enc(input logic [W:0] v);
		logic [TXW-1:0] r;
		r = '0;
		for (int i = 0; i <= W; i++)
			if (v[i]) r = r | TXW'(i);
		return r;
	endfunction

	state_t state_q;
	logic [W-1:0] mem [MAX_TILES_Y];
	logic [W-1:0] rd_q;
	logic [RAW-1:0] rd_addr;
	logic [MAX_TILES_Y-1:0] known_q;
	logic known_s1;
	logic fill_q, flag_q;
	logic wr_s1;
	logic [RAW-1:0] wa_s1;
	logic [W-1:0] mask_q, vec_q;
	logic [TYW-1:0] row_q, ey_q;
	logic [RECTS_W-1:0] count_q, cap;
	logic pend_v_q;
	rect_t pend_q, run_rect, out_rect_q;
	logic out_v_q, out_last_q, out_valid_q, out_any_q;

	logic [W-1:0] rowval, colmask, lsb, mkmask;
	logic [W:0] t, endhot;
	logic [TXW-1:0] run_start, run_end;
	logic [XCW-1:0] x2w;
	logic [YCW-1:0] y2w;
	logic [TYW-1:0] row_nx;
	logic out_free;
	logic out_load;

	assign rd_addr = row_q[RAW-1:0];
	assign rowval = known_s1 ? rd_q : {W{fill_q}};
	assign out_free = !out_v_q || m_tready;
	// The output register takes a new word in this cycle.
	assign out_load = out_free && ((state_q == ST_WHOLE) || (state_q == ST_END) ||
		(state_q == ST_RUNS && vec_q != '0 && pend_v_q));
	assign q_ready = (state_q == ST_IDLE);
	assign cap = (max_rects == '0) ? RECTS_W'(1) :
		((max_rects > CAP_LIMIT) ? CAP_LIMIT : max_rects);

	always_comb begin
		for (int i = 0; i < W; i++) begin
			colmask[i] = (TXW'(i) < ntx);
			mkmask[i] = (TXW'(i) >= q_sx) && (TXW'(i) < q_ex);
		end
		// The lowest set bit starts a run; adding it carries out at the run's end.
		lsb = vec_q & (~vec_q + W'(1));
		t = {1'b0, vec_q} + {1'b0, lsb};
		endhot = t & ~{1'b0, vec_q};
		run_start = enc({1'b0, lsb});
		run_end = enc(endhot);
		row_nx = row_q + TYW'(1);
		x2w = XCW'({run_end, {TILE_LOG2{1'b0}}});
		y2w = YCW'({row_nx, {TILE_LOG2{1'b0}}});
		run_rect.x1 = PIX_W'(XCW'({run_start, {TILE_LOG2{1'b0}}}));
		run_rect.y1 = PIX_W'(YCW'({row_q, {TILE_LOG2{1'b0}}}));
		run_rect.x2 = (x2w > XCW'(screen_width)) ? screen_width : PIX_W'(x2w);
		run_rect.y2 = (y2w > YCW'(screen_height)) ? screen_height : PIX_W'(y2w);
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (wr_s1) mem[wa_s1] <= rowval | mask_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			known_q <= '0;
			known_s1 <= 1'b0;
			fill_q <= 1'b1;
			flag_q <= 1'b1;
			wr_s1 <= 1'b0;
			pend_v_q <= 1'b0;
			count_q <= '0;
			out_v_q <= 1'b0;
			row_q <= '0;
		end else begin
			known_s1 <= known_q[rd_addr];
			wr_s1 <= (state_q == ST_MARK);
			if (wr_s1) known_q[wa_s1] <= 1'b1;
			if (out_v_q && m_tready && !out_load) out_v_q <= 1'b0;
			if (cfg_mark_all) begin
				fill_q <= 1'b1;
				flag_q <= 1'b1;
				known_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						case (q_kind)
							CMD_MARK: begin
								row_q <= q_sy;
								ey_q <= q_ey;
								mask_q <= mkmask;
								state_q <= ST_MARK;
							end
							CMD_ALL: begin
								fill_q <= 1'b1;
								flag_q <= 1'b1;
								known_q <= '0;
							end
							CMD_FLUSH: begin
								row_q <= '0;
								count_q <= '0;
								pend_v_q <= 1'b0;
								state_q <= flag_q ? ST_WHOLE : ST_RD;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_MARK: begin
					wa_s1 <= rd_addr;
					row_q <= row_nx;
					if (row_nx == ey_q) state_q <= ST_MDRAIN;
				end
				ST_MDRAIN: state_q <= ST_IDLE;
				ST_WHOLE: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						out_valid_q <= 1'b1;
						out_any_q <= 1'b1;
						out_last_q <= 1'b1;
						out_rect_q <= '{x1: '0, y1: '0, x2: screen_width, y2: screen_height};
						state_q <= ST_CLEAR;
					end
				end
				ST_RD: state_q <= (row_q >= nty) ? ST_END : ST_WAIT;
				ST_WAIT: begin
					vec_q <= rowval & colmask;
					state_q <= ST_RUNS;
				end
				ST_RUNS: begin
					if (vec_q == '0) begin
						row_q <= row_nx;
						state_q <= ST_RD;
					end else if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_v_q <= 1'b1;
							out_valid_q <= 1'b1;
							out_any_q <= 1'b1;
							out_last_q <= 1'b0;
							out_rect_q <= pend_q;
						end
						pend_q <= run_rect;
						pend_v_q <= 1'b1;
						vec_q <= vec_q & t[W-1:0];
						count_q <= count_q + RECTS_W'(1);
						if ((count_q + RECTS_W'(1)) >= cap) state_q <= ST_END;
					end
				end
				ST_END: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						out_valid_q <= pend_v_q;
						out_any_q <= pend_v_q;
						out_last_q <= 1'b1;
						out_rect_q <= pend_v_q ? pend_q : '0;
						state_q <= ST_CLEAR;
					end
				end
				ST_CLEAR: begin
					fill_q <= 1'b0;
					flag_q <= 1'b0;
					known_q <= '0;
					pend_v_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {4'b0, out_rect_q.y2, out_rect_q.x2, out_rect_q.y1, out_rect_q.x1};
	assign m_tuser = {out_any_q, out_valid_q};
	assign m_tlast = out_last_q;

	a_clear_drops_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=> !flag_q)
		else $error("whole-screen flag survived a flush");
	a_cap_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUNS) |-> (count_q < cap))
		else $error("run scan went past the rectangle cap");
	a_mark_in_screen: assert property (@(posedge clk) disable iff (!arst_n)
		wr_s1 |-> (TYW'(wa_s1) < nty))
		else $error("mark wrote a row outside the screen");
	a_flush_no_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_END && out_free) |=> (state_q == ST_CLEAR && out_v_q && out_last_q))
		else $error("flush ended without a final word");

endmodule

### hw/rtl/dirty_tile_tracker.sv
// Dirty tile tracker top level: configuration registers, tile counts, and
// the front and back ends. Depends on dtt_pkg, dtt_front and dtt_back.
//
// Usage: commands arrive on the s_ stream (tuser = command, tdata = region).
// Mark-region and mark-whole-screen commands give no output; a flush gives
// one or more result words on the m_ stream, tlast on the final one.
// A mark works through the tile rows it touches one by one; unless the whole
// screen is dirty, a flush reads each tile row and scans it for runs until the
// cap is reached, paced by the single read port of the row memory (128 rows by
// default). A two-entry command queue lets new commands be accepted while the
// back end works. A result waits in the output register while m_tready is low,
// which stalls the scan; the queue then fills and s_tready drops.
// After reset the screen is 1024 x 768, the cap is one rectangle, and the whole
// screen counts as dirty. Writing screen_width or screen_height marks everything
// dirty again. The user must write configuration only while idle; it is not enforced.
module dirty_tile_tracker import dtt_pkg::*; #(
	parameter int MAX_TILES_X = DEF_MAX_TILES_X,
	parameter int MAX_TILES_Y = DEF_MAX_TILES_Y
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // x[11:0], y[23:12], region_width[36:24], region_height[49:37]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // x1[12:0], y1[25:13], x2[38:26], y2[51:39]
	output logic [1:0]  m_tuser,   // rect_valid[0], any_dirty[1]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int TXW = $clog2(MAX_TILES_X + 1);
	localparam int TYW = $clog2(MAX_TILES_Y + 1);

	logic [PIX_W-1:0] sw_q, sh_q;
	logic [RECTS_W-1:0] mr_q;
	logic [13:0] tx_w, ty_w;
	logic [TXW-1:0] ntx;
	logic [TYW-1:0] nty;
	logic cfg_mark_all;

	logic q_valid, q_ready;
	cmd_t q_kind;
	logic [TXW-1:0] q_sx, q_ex;
	logic [TYW-1:0] q_sy, q_ey;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= RST_SCREEN_WIDTH;
			sh_q <= RST_SCREEN_HEIGHT;
			mr_q <= RST_MAX_RECTS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  sw_q <= cfg_data;
				REG_SCREEN_HEIGHT: sh_q <= cfg_data;
				REG_MAX_RECTS:     mr_q <= cfg_data[RECTS_W-1:0];
				default:           sw_q <= sw_q;
			endcase
		end
	end

	assign cfg_mark_all = cfg_we &&
		(cfg_index == REG_SCREEN_WIDTH || cfg_index == REG_SCREEN_HEIGHT);

	always_comb begin
		tx_w = (14'(sw_q) + 14'(TILE_SIZE - 1)) >> TILE_LOG2;
		ty_w = (14'(sh_q) + 14'(TILE_SIZE - 1)) >> TILE_LOG2;
		ntx = (tx_w > 14'(MAX_TILES_X)) ? TXW'(MAX_TILES_X) : tx_w[TXW-1:0];
		nty = (ty_w > 14'(MAX_TILES_Y)) ? TYW'(MAX_TILES_Y) : ty_w[TYW-1:0];
	end

	dtt_front #(.MAX_TILES_X(MAX_TILES_X), .MAX_TILES_Y(MAX_TILES_Y)) u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.ntx(ntx), .nty(nty),
		.q_valid(q_valid), .q_ready(q_ready), .q_kind(q_kind),
		.q_sx(q_sx), .q_ex(q_ex), .q_sy(q_sy), .q_ey(q_ey)
	);

	dtt_back #(.MAX_TILES_X(MAX_TILES_X), .MAX_TILES_Y(MAX_TILES_Y)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_kind(q_kind),
		.q_sx(q_sx), .q_ex(q_ex), .q_sy(q_sy), .q_ey(q_ey),
		.ntx(ntx), .nty(nty),
		.screen_width(sw_q), .screen_height(sh_q), .max_rects(mr_q),
		.cfg_mark_all(cfg_mark_all),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

endmodule
